### sv/lhm_pkg.sv
package lhm_pkg;

   // Field widths of the request and response payloads.
   localparam int KIND_W   = 2;
   localparam int POS_W    = 11;
   localparam int LETTER_W = 5;
   localparam int COUNT_W  = 11;

   // Histogram geometry.
   localparam int NUM_BINS = 26;
   localparam int BIN_W    = 5;
   localparam logic [BIN_W-1:0]   BIN_LAST  = BIN_W'(NUM_BINS - 1);
   localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

   // Request kinds carried on tuser.
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_QUERY   = 2'd1,
      KIND_REPLACE = 2'd2
   } kind_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OLD_RD,
      ST_OLD_WR,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_INC_RD,
      ST_INC_WR
   } state_type;

   // Write port of the count memory.
   typedef struct packed {
      logic               we;
      logic [BIN_W-1:0]   addr;
      logic [COUNT_W-1:0] data;
   } cnt_wr_type;

endpackage

### sv/lhm_letter_store.sv
module lhm_letter_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [lhm_pkg::LETTER_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [lhm_pkg::LETTER_W-1:0]  rd_data
);
   import lhm_pkg::*;

   logic [LETTER_W-1:0] mem_ff [DEPTH];
   logic [LETTER_W-1:0] rd_data_ff;

   // Single write port and one registered read port; contents start undefined.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lhm_count_store.sv
module lhm_count_store (
   input  logic                         clock,
   input  logic                         reset,
   input  lhm_pkg::cnt_wr_type          wr,
   input  logic [lhm_pkg::BIN_W-1:0]    rd_addr,
   output logic [lhm_pkg::COUNT_W-1:0]  rd_data
);
   import lhm_pkg::*;

   logic [COUNT_W-1:0]  mem_ff [NUM_BINS];
   logic [NUM_BINS-1:0] vld_ff;
   logic [COUNT_W-1:0]  rd_data_ff;

   // Valid bits make every bin read as zero after reset until first written.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.we) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   // Count storage with a registered read; a same-cycle write is not forwarded.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= vld_ff[rd_addr] ? mem_ff[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/letter_histogram_max_tracker.sv
// Query: the result is valid in the cycle after acceptance, and a
// taken result frees the request side in that same cycle. Load: count read,
// then count write. Replace: letter read, old bin read, old bin write, new bin
// read, new bin write; when the old letter's bin held the maximum, a rescan that
// reads the 26 bins one per cycle comes between the old bin write and the new bin read.
// Reset clears the bins (by valid bits), the maximum and all control state.
module letter_histogram_max_tracker #(
   parameter int MAX_LEN = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [10:0] position, [15:11] letter
   input  logic [1:0]   req_tuser,   // [1:0] kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata    // [10:0] max_count, [15:11] zero
);
   import lhm_pkg::*;

   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int WIDE_W = 17;

   // Request fields.
   logic [POS_W-1:0]    req_position;
   logic [LETTER_W-1:0] req_letter;
   logic [KIND_W-1:0]   req_kind;
   logic [WIDE_W-1:0]   req_slot_wide;
   logic [ADDR_W-1:0]   req_slot;
   logic                req_ok;

   assign req_position  = req_tdata[POS_W-1:0];
   assign req_letter    = req_tdata[POS_W +: LETTER_W];
   assign req_kind      = req_tuser;
   assign req_slot_wide = WIDE_W'(req_position) - WIDE_W'(1);
   assign req_slot      = req_slot_wide[ADDR_W-1:0];
   assign req_ok        = (req_position != '0)
                       && (WIDE_W'(req_position) <= WIDE_W'(MAX_LEN))
                       && (req_letter <= BIN_LAST);

   // Control and payload registers.
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic [BIN_W-1:0]    letter_ff, letter_in;
   logic [BIN_W-1:0]    old_ff, old_in;
   logic [BIN_W-1:0]    idx_ff, idx_in;
   logic [COUNT_W-1:0]  greatest_ff, greatest_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic                st_we;
   logic [ADDR_W-1:0]   st_wr_addr;
   logic [LETTER_W-1:0] st_wr_data;
   logic [LETTER_W-1:0] st_rd_data;
   cnt_wr_type          cnt_wr;
   logic [BIN_W-1:0]    cnt_rd_addr;
   logic [COUNT_W-1:0]  cnt_rd_data;
   logic [COUNT_W-1:0]  cnt_next;

   lhm_letter_store #(
      .DEPTH  (MAX_LEN),
      .ADDR_W (ADDR_W)
   ) u_letter_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (req_slot),
      .rd_data (st_rd_data)
   );

   lhm_count_store u_count_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (cnt_wr),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // Saturating increment of the bin just read.
   assign cnt_next = (cnt_rd_data == COUNT_TOP) ? cnt_rd_data : cnt_rd_data + COUNT_W'(1);

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         greatest_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         greatest_ff  <= greatest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      letter_ff   <= letter_in;
      old_ff      <= old_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequencer: answer queries from the held maximum; read, modify and write back the bins, rescanning when needed.
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      letter_in    = letter_ff;
      old_in       = old_ff;
      idx_in       = idx_ff;
      greatest_in  = greatest_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      st_we        = 1'b0;
      st_wr_addr   = slot_ff;
      st_wr_data   = letter_ff;
      cnt_wr       = '0;
      cnt_rd_addr  = letter_ff;

      // The response register empties when its response is taken.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_tvalid && req_tready) begin
               slot_in   = req_slot;
               letter_in = req_letter;
               if (req_kind == KIND_QUERY) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = greatest_ff;
               end else if (req_ok && req_kind == KIND_LOAD) begin
                  st_we       = 1'b1;
                  st_wr_addr  = req_slot;
                  st_wr_data  = req_letter;
                  cnt_rd_addr = req_letter;
                  state_in    = ST_INC_WR;
               end else if (req_ok && req_kind == KIND_REPLACE) begin
                  // The letter store read at req_slot is already under way.
                  state_in = ST_OLD_RD;
               end
            end
         end

         ST_OLD_RD: begin
            // Old letter is out; fetch its bin and overwrite the slot.
            old_in      = (st_rd_data > BIN_LAST) ? '0 : st_rd_data;
            cnt_rd_addr = old_in;
            st_we       = 1'b1;
            state_in    = ST_OLD_WR;
         end

         ST_OLD_WR: begin
            cnt_wr.we   = 1'b1;
            cnt_wr.addr = old_ff;
            cnt_wr.data = (cnt_rd_data != '0) ? cnt_rd_data - COUNT_W'(1) : cnt_rd_data;
            if (cnt_rd_data == greatest_ff) begin
               greatest_in = '0;
               idx_in      = '0;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_INC_RD;
            end
         end

         ST_SCAN: begin
            // Issue one bin read a cycle and fold in the previous bin.
            cnt_rd_addr = idx_ff;
            if (idx_ff != '0 && cnt_rd_data > greatest_ff) begin
               greatest_in = cnt_rd_data;
            end
            idx_in = idx_ff + BIN_W'(1);
            if (idx_ff == BIN_LAST) begin
               state_in = ST_SCAN_LAST;
            end
         end

         ST_SCAN_LAST: begin
            if (cnt_rd_data > greatest_ff) begin
               greatest_in = cnt_rd_data;
            end
            cnt_rd_addr = letter_ff;
            state_in    = ST_INC_WR;
         end

         ST_INC_RD: begin
            // Separate read so a write to the same bin has landed.
            cnt_rd_addr = letter_ff;
            state_in    = ST_INC_WR;
         end

         ST_INC_WR: begin
            cnt_wr.we   = 1'b1;
            cnt_wr.addr = letter_ff;
            cnt_wr.data = cnt_next;
            if (cnt_next > greatest_ff) begin
               greatest_in = cnt_next;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(16 - COUNT_W)'(0), rsp_data_ff};

endmodule

### tb/letter_histogram_max_tracker_tb.sv
module letter_histogram_max_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lhm_pkg::*;

   localparam int TEXT_LEN = 1024;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;    // [10:0] position, [15:11] letter
   logic [1:0]          req_tuser = '0;    // [1:0] kind
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;         // [10:0] max_count, [15:11] zero

   // Shadow state of the histogram, updated on every accepted request.
   logic [LETTER_W-1:0] text_letters [TEXT_LEN];
   bit                  text_loaded [TEXT_LEN];
   int                  loaded_slots [$];
   logic [COUNT_W-1:0]  letter_bins [NUM_BINS];
   logic [COUNT_W-1:0]  peak_count;
   logic [COUNT_W-1:0]  expected_peaks [$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  fail_count = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   bit  hold_toggle = 1'b0;
   bit  hold_seen = 1'b0;

   letter_histogram_max_tracker #(
      .MAX_LEN(TEXT_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Recompute the maximum over all bins, as the block does after lowering the top bin.
   function automatic void rescan_peak();
      peak_count = '0;
      for (int b = 0; b < NUM_BINS; b++) begin
         if (letter_bins[b] > peak_count) peak_count = letter_bins[b];
      end
   endfunction

   // Apply one accepted request to the shadow state and queue any response it causes.
   function automatic void track_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                         logic [LETTER_W-1:0] letter);
      int                  slot;
      logic [LETTER_W-1:0] old_letter;
      logic [COUNT_W-1:0]  was;
      if (kind == KIND_QUERY) begin
         expected_peaks.push_back(peak_count);
         return;
      end
      if (kind != KIND_LOAD && kind != KIND_REPLACE) return;
      if (pos == 0 || pos > TEXT_LEN || letter >= NUM_BINS) return;
      slot = int'(pos) - 1;
      if (kind == KIND_REPLACE) begin
         old_letter = text_letters[slot];
         was = letter_bins[old_letter];
         if (was > 0) letter_bins[old_letter] = was - COUNT_W'(1);
         if (was == peak_count) rescan_peak();
      end
      text_letters[slot] = letter;
      if (!text_loaded[slot]) begin
         text_loaded[slot] = 1'b1;
         loaded_slots.push_back(slot);
      end
      if (letter_bins[letter] != COUNT_TOP) begin
         letter_bins[letter] = letter_bins[letter] + COUNT_W'(1);
      end
      if (letter_bins[letter] > peak_count) peak_count = letter_bins[letter];
   endfunction

   // Offer one request, with random idle cycles ahead of it, and wait until it is taken.
   task automatic send_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic [LETTER_W-1:0] letter);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {letter, pos};
      do @(posedge clock); while (!req_tready);
      track_request(kind, pos, letter);
   endtask

   // Stop offering requests until every pending response has come back.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_peaks.size() != 0);
   endtask

   // Draw one request: mostly well-formed loads, queries and replaces over a few
   // letters and a narrow window of positions, plus some that the block must ignore.
   task automatic send_random_request();
      int                  pick;
      logic [POS_W-1:0]    pos;
      logic [LETTER_W-1:0] letter;
      pick = $urandom_range(99);
      letter = $urandom_range(1) ? LETTER_W'($urandom_range(3)) : LETTER_W'($urandom_range(25));
      pos = ($urandom_range(3) != 0) ? POS_W'($urandom_range(48, 1))
                                     : POS_W'($urandom_range(TEXT_LEN, 1));
      if (pick < 55 && pick >= 30) begin
         send_request(KIND_QUERY, POS_W'($urandom), LETTER_W'($urandom));
      end else if (pick < 90 && pick >= 55 && loaded_slots.size() != 0) begin
         pos = POS_W'(loaded_slots[$urandom_range(loaded_slots.size() - 1)] + 1);
         send_request(KIND_REPLACE, pos, letter);
      end else if (pick < 90) begin
         send_request(KIND_LOAD, pos, letter);
      end else begin
         case ($urandom_range(3))
            0: send_request(KIND_UNUSED, POS_W'($urandom), LETTER_W'($urandom));
            1: send_request($urandom_range(1) ? KIND_LOAD : KIND_REPLACE,
                            $urandom_range(1) ? POS_W'(0) : POS_W'($urandom_range(2047, 1025)),
                            letter);
            2: send_request(KIND_LOAD, pos, LETTER_W'($urandom_range(31, 26)));
            default: begin
               if (loaded_slots.size() != 0) begin
                  pos = POS_W'(loaded_slots[$urandom_range(loaded_slots.size() - 1)] + 1);
               end
               send_request(KIND_REPLACE, pos, LETTER_W'($urandom_range(31, 26)));
            end
         endcase
      end
   endtask

   // Field extremes, both rescan paths and every kind of ignored request.
   task automatic test_directed();
      send_idle_pct = 20;
      recv_idle_pct = 20;
      send_request(KIND_QUERY, '0, '0);
      send_request(KIND_LOAD, 11'd1, 5'd0);
      send_request(KIND_QUERY, '1, '1);
      send_request(KIND_LOAD, 11'd1024, 5'd25);
      send_request(KIND_LOAD, 11'd1024, 5'd25);
      send_request(KIND_QUERY, '0, '0);
      // The old letter holds the maximum, so the replace forces a rescan.
      send_request(KIND_REPLACE, 11'd1024, 5'd0);
      send_request(KIND_QUERY, '0, '0);
      send_request(KIND_LOAD, 11'd2, 5'd16);
      // Here the old letter sits below the maximum: no rescan.
      send_request(KIND_REPLACE, 11'd2, 5'd15);
      send_request(KIND_REPLACE, 11'd1, 5'd16);
      send_request(KIND_QUERY, '0, '0);
      // Requests the block has to drop without touching its state.
      send_request(KIND_UNUSED, 11'd3, 5'd3);
      send_request(KIND_UNUSED, '1, '1);
      send_request(KIND_LOAD, 11'd0, 5'd5);
      send_request(KIND_LOAD, 11'd1025, 5'd5);
      send_request(KIND_LOAD, 11'd2047, 5'd5);
      send_request(KIND_LOAD, 11'd4, 5'd26);
      send_request(KIND_LOAD, 11'd4, 5'd31);
      send_request(KIND_REPLACE, 11'd0, 5'd5);
      send_request(KIND_REPLACE, 11'd2047, 5'd5);
      send_request(KIND_REPLACE, 11'd1, 5'd31);
      send_request(KIND_QUERY, '0, '0);
   endtask

   task automatic test_random_traffic(int count, int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_random_request();
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the response register fills and the request side stalls.
   task automatic test_response_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_toggle <= ~hold_toggle;
      repeat (60) send_random_request();
   endtask

   task automatic test_sender_pause();
      wait_for_responses();
      repeat (20) send_random_request();
   endtask

   // Response checking and receiver ready, with an optional long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_peaks.size() == 0) begin
            $error("max_count: response %0d with no query pending", rsp_tdata[COUNT_W-1:0]);
            fail_count++;
         end else if (rsp_tdata[COUNT_W-1:0] !== expected_peaks[0]) begin
            $error("max_count: expected %0d, actual %0d", expected_peaks[0],
                   rsp_tdata[COUNT_W-1:0]);
            fail_count++;
            void'(expected_peaks.pop_front());
         end else begin
            void'(expected_peaks.pop_front());
         end
      end
      if (hold_seen != hold_toggle) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles in which neither side moves anything.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("letter_histogram_max_tracker test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int b = 0; b < NUM_BINS; b++) letter_bins[b] = '0;
      peak_count = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(470, 38, 54);
      test_response_backpressure();
      test_random_traffic(470, 54, 38);
      test_sender_pause();
      test_random_traffic(500, 0, 0);

      wait_for_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_peaks.size() != 0) begin
         $error("max_count: %0d expected responses never arrived", expected_peaks.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("letter_histogram_max_tracker test passed");
      end else begin
         $display("letter_histogram_max_tracker test failed");
      end
      $finish;
   end

endmodule
